>>> rtl/core/mcg_pkg.sv
// Package for the metronome click generator: types, register map, defaults, sine table function.
`timescale 1ns / 1ps
package mcg_pkg;

  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
  localparam int unsigned POSITION_WIDTH_DEF   = 48;

  localparam logic [2:0] REG_ACTIVE    = 3'd0;
  localparam logic [2:0] REG_GAIN      = 3'd1;
  localparam logic [2:0] REG_BPB       = 3'd2;
  localparam logic [2:0] REG_SPB       = 3'd3;
  localparam logic [2:0] REG_CLICK_LEN = 3'd4;
  localparam logic [2:0] REG_SEEK_TOL  = 3'd5;
  localparam logic [2:0] REG_HIGH_STEP = 3'd6;
  localparam logic [2:0] REG_LOW_STEP  = 3'd7;

  localparam logic [15:0] GAIN_RST      = 16'd16384;
  localparam logic [4:0]  BPB_RST       = 5'd4;
  localparam logic [31:0] SPB_RST       = 32'd6144000;
  localparam logic [15:0] CLICK_LEN_RST = 16'd1440;
  localparam logic [15:0] SEEK_TOL_RST  = 16'd240;
  localparam logic [22:0] HIGH_STEP_RST = 23'd349525;
  localparam logic [22:0] LOW_STEP_RST  = 23'd279620;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BDIV, ST_BEAT, ST_PHASE, ST_INDEX, ST_ROM,
    ST_ENV, ST_GAIN, ST_CSET, ST_CDIV, ST_SAT, ST_DONE
  } mcg_state_t;

  // Quarter-wave magnitude for table phase j of a 2^lg entry cycle.
  function automatic logic [14:0] sine_mag(input int unsigned j, input int unsigned lg);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic [63:0]        Div_n;
    logic signed [63:0] sum;
    x    = ((64'(j) << 2) * HALF_PI_Q30) >> lg;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      Div_n = 64'((2 * n) * (2 * n + 1));
      term  = ((term * x2) >> 30) / Div_n;
      if ((n % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

>>> rtl/core/metronome_click_generator.sv
// Metronome click generator top level: APB registers, sequencer, shared divider and multiplier.
`timescale 1ns / 1ps
// Usage:
//  req channel (req_valid/req_ready) carries one word per audio sample:
//  kind 0 is a sample tick, kind 1 a seek to seek_position.
//  rsp channel (rsp_valid/rsp_ready) returns one word per request:
//  sample (Q1.15), beat_start and accent.
//  Registers sit on the APB port at 4*index. The user must write
//  them only while idle; the block does not enforce it. One request
//  is in work at a time; req_ready is low meanwhile.
//  A bit-serial restoring divider of DW = max(POSITION_WIDTH+8, 49)
//  steps finds the beat index and later the rounded click amplitude;
//  one 32x23 multiplier is reused for phase, envelope and gain.
//  A finished word waits in the output register while the next request
//  is taken; a stalled receiver holds the sequencer in its last state
//  only once a second word is ready.
//  Reset clears position, beat tracking and the click, and loads the
//  register defaults; the block comes out of reset inactive.
module metronome_click_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = mcg_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int unsigned POSITION_WIDTH   = mcg_pkg::POSITION_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               kind,
  input  logic signed [47:0] seek_position,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [15:0] sample,
  output logic               beat_start,
  output logic               accent
);
  import mcg_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned DW = (PW + 8 > 49) ? PW + 8 : 49;
  localparam int unsigned BW = (PW + 8 > 64) ? 64 : PW + 8;
  localparam int unsigned CW = $clog2(DW);
  localparam int unsigned LG = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QD = SINE_TABLE_DEPTH / 4;
  localparam int unsigned QN = QD + 1;

  logic        active;
  logic [15:0] gain;
  logic [4:0]  beats_per_bar;
  logic [31:0] samples_per_beat_q8;
  logic [15:0] click_length;
  logic [15:0] seek_tolerance;
  logic [22:0] high_phase_step;
  logic [22:0] low_phase_step;

  mcg_state_t state, state_next;

  logic [PW-1:0] position;
  logic [BW-1:0] last_beat;
  logic          last_valid;
  logic [15:0]   click_pos;
  logic          click_run;
  logic          accent_flag;
  logic          kind_q;

  logic [DW-1:0] dvd;
  logic [31:0]   rem;
  logic [31:0]   dvs;
  logic [CW-1:0] cnt;
  logic [4:0]    bmod;

  logic [54:0]   prod;
  logic [31:0]   mul_a;
  logic [22:0]   mul_b;
  logic [LG-2:0] rom_idx;
  logic          sine_neg;
  logic [14:0]   mag_s;
  logic [14:0]   rom [QN];

  logic [15:0]   res_sample;
  logic          res_bs;
  logic          res_acc;

  logic          cfg_wr;
  logic          take;
  logic          load_out;
  logic [63:0]   seek_ext;
  logic [PW-1:0] seek_pos;
  logic [PW-1:0] pos_inc;
  logic [32:0]   rem_sh;
  logic          q_bit;
  logic [31:0]   rem_nx;
  logic [5:0]    mod_t;
  logic [4:0]    bpb_eff;
  logic [4:0]    bmod_nx;
  logic          mod_en;
  logic [BW-1:0] beat;
  logic [24:0]   seek_off;
  logic          new_beat;
  logic [15:0]   eff_pos;
  logic          will_click;
  logic [LG-1:0] tab_idx;
  logic [15:0]   env;
  logic [DW-1:0] click_num;
  logic [15:0]   sat_val;
  logic          q_big;

  for (genvar g = 0; g < QN; g++) begin : g_rom
    assign rom[g] = sine_mag(g, LG);
  end

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain                <= GAIN_RST;
      beats_per_bar       <= BPB_RST;
      samples_per_beat_q8 <= SPB_RST;
      click_length        <= CLICK_LEN_RST;
      seek_tolerance      <= SEEK_TOL_RST;
      high_phase_step     <= HIGH_STEP_RST;
      low_phase_step      <= LOW_STEP_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_GAIN:      gain                <= pwdata[15:0];
        REG_BPB:       beats_per_bar       <= pwdata[4:0];
        REG_SPB:       samples_per_beat_q8 <= pwdata;
        REG_CLICK_LEN: click_length        <= pwdata[15:0];
        REG_SEEK_TOL:  seek_tolerance      <= pwdata[15:0];
        REG_HIGH_STEP: high_phase_step     <= pwdata[22:0];
        REG_LOW_STEP:  low_phase_step      <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ACTIVE:    prdata = {31'd0, active};
      REG_GAIN:      prdata = {16'd0, gain};
      REG_BPB:       prdata = {27'd0, beats_per_bar};
      REG_SPB:       prdata = samples_per_beat_q8;
      REG_CLICK_LEN: prdata = {16'd0, click_length};
      REG_SEEK_TOL:  prdata = {16'd0, seek_tolerance};
      REG_HIGH_STEP: prdata = {9'd0, high_phase_step};
      REG_LOW_STEP:  prdata = {9'd0, low_phase_step};
      default:       prdata = 32'd0;
    endcase
  end

  // datapath helpers
  assign seek_ext = 64'(seek_position);
  assign seek_pos = seek_ext[PW-1:0];
  assign pos_inc  = position + PW'(1);

  assign rem_sh = {rem, dvd[DW-1]};
  assign q_bit  = rem_sh >= {1'b0, dvs};
  assign rem_nx = q_bit ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];

  assign bpb_eff = (beats_per_bar == 5'd0) ? 5'd1 : beats_per_bar;
  assign mod_t   = {bmod, q_bit};
  assign bmod_nx = (mod_t >= {1'b0, bpb_eff}) ? 5'(mod_t - {1'b0, bpb_eff}) : mod_t[4:0];
  assign mod_en  = (DW <= 64) || ({1'b0, cnt} < (CW + 1)'(64));

  assign beat       = dvd[BW-1:0];
  assign seek_off   = 25'((33'(rem) + 33'd255) >> 8);
  assign new_beat   = !last_valid || (beat != last_beat);
  assign eff_pos    = new_beat ? 16'd0 : click_pos;
  assign will_click = (new_beat || click_run) && (eff_pos < click_length);

  assign tab_idx   = prod[23 -: LG];
  assign env       = click_length - click_pos;
  assign click_num = DW'({prod[47:0], 1'b0}) + DW'({click_length, 14'd0});
  assign q_big     = |dvd[DW-1:16];

  always_comb begin
    if (sine_neg) begin
      sat_val = (q_big || (dvd[15:0] > 16'h8000)) ? 16'h8000 : 16'(-dvd[15:0]);
    end else begin
      sat_val = (q_big || dvd[15]) ? 16'h7FFF : dvd[15:0];
    end
  end

  always_comb begin
    case (state)
      ST_PHASE: begin
        mul_a = 32'(click_pos);
        mul_b = accent_flag ? high_phase_step : low_phase_step;
      end
      ST_ENV: begin
        mul_a = 32'(mag_s);
        mul_b = 23'(env);
      end
      ST_GAIN: begin
        mul_a = prod[31:0];
        mul_b = 23'(gain);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 23'd0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    take       = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        take      = req_valid;
        if (req_valid) begin
          if (kind) begin
            state_next = (samples_per_beat_q8 != 32'd0 && !seek_pos[PW-1]) ? ST_BDIV
                                                                             : ST_DONE;
          end else if (active && samples_per_beat_q8 != 32'd0 && !position[PW-1]) begin
            state_next = ST_BDIV;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_BDIV:  if (cnt == '0) state_next = ST_BEAT;
      ST_BEAT:  state_next = (!kind_q && will_click) ? ST_PHASE : ST_DONE;
      ST_PHASE: state_next = ST_INDEX;
      ST_INDEX: state_next = ST_ROM;
      ST_ROM:   state_next = ST_ENV;
      ST_ENV:   state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_CSET;
      ST_CSET:  state_next = ST_CDIV;
      ST_CDIV:  if (cnt == '0) state_next = ST_SAT;
      ST_SAT:   state_next = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      position    <= '0;
      last_valid  <= 1'b0;
      click_run   <= 1'b0;
      accent_flag <= 1'b0;
    end else begin
      if (cfg_wr && paddr[4:2] == REG_ACTIVE) begin
        active    <= pwdata[0];
        click_run <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take && kind) begin
            position  <= seek_pos;
            click_run <= 1'b0;
            if (samples_per_beat_q8 == 32'd0 || seek_pos[PW-1]) begin
              last_valid <= 1'b0;
            end
          end else if (take && active && samples_per_beat_q8 != 32'd0
                       && position[PW-1]) begin
            position <= pos_inc;
          end
        end
        ST_BEAT: begin
          if (kind_q) begin
            if (seek_off <= 25'(seek_tolerance)) begin
              last_valid <= (beat != '0);
              last_beat  <= beat - BW'(1);
            end else begin
              last_valid <= 1'b1;
              last_beat  <= beat;
            end
          end else begin
            position <= pos_inc;
            if (new_beat) begin
              last_beat   <= beat;
              last_valid  <= 1'b1;
              accent_flag <= (bmod == 5'd0);
              click_pos   <= 16'd0;
              click_run   <= 1'b1;
            end
          end
        end
        ST_SAT: begin
          click_pos <= click_pos + 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        kind_q     <= kind;
        res_sample <= 16'd0;
        res_bs     <= 1'b0;
        res_acc    <= 1'b0;
        dvd        <= DW'({(kind ? seek_pos : position), 8'd0});
        rem        <= 32'd0;
        dvs        <= samples_per_beat_q8;
        cnt        <= CW'(DW - 1);
        bmod       <= 5'd0;
      end
      ST_BDIV, ST_CDIV: begin
        dvd <= {dvd[DW-2:0], q_bit};
        rem <= rem_nx;
        cnt <= cnt - CW'(1);
        if (mod_en) begin
          bmod <= bmod_nx;
        end
      end
      ST_BEAT: begin
        if (!kind_q && new_beat) begin
          res_bs <= 1'b1;
        end
      end
      ST_PHASE, ST_ENV, ST_GAIN: begin
        prod <= 55'(mul_a * mul_b);
      end
      ST_INDEX: begin
        sine_neg <= tab_idx[LG-1];
        rom_idx  <= tab_idx[LG-2] ? (LG - 1)'(QD) - {1'b0, tab_idx[LG-3:0]}
                                  : {1'b0, tab_idx[LG-3:0]};
      end
      ST_ROM: begin
        mag_s <= rom[rom_idx];
      end
      ST_CSET: begin
        dvd <= click_num;
        rem <= 32'd0;
        dvs <= {1'b0, click_length, 15'd0};
        cnt <= CW'(DW - 1);
      end
      ST_SAT: begin
        res_sample <= sat_val;
        res_acc    <= accent_flag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample     <= res_sample;
      beat_start <= res_bs;
      accent     <= res_acc;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BDIV || state == ST_CDIV) |-> (rem < dvs))
    else $error("divider remainder not below divisor");

  a_beat_tracked: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_bs) |-> last_valid)
    else $error("beat start without a tracked beat");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");
`endif

endmodule

>>> tb/sv/mcg_checker.sv
// Checker for the metronome click generator: tracks registers, predicts each word, compares.
`timescale 1ns / 1ps
module mcg_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               req_valid,
  input  logic               req_ready,
  input  logic               kind,
  input  logic signed [47:0] seek_position,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  logic signed [15:0] sample,
  input  logic               beat_start,
  input  logic               accent,
  output int                 errors,
  output int                 pending
);
  import mcg_pkg::*;

  localparam int TBL_DEPTH = 1024;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam longint unsigned POS_MASK = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [15:0] smp;
    logic               bs;
    logic               acc;
  } click_word_t;

  click_word_t expected_words[$];

  logic [15:0] r_gain, r_len, r_tol;
  logic [4:0]  r_bpb;
  logic [31:0] r_spb;
  logic [22:0] r_hstep, r_lstep;
  logic        r_active;

  longint unsigned pos, last_beat;
  bit  last_ok, acc_flag;
  int  click_pos;
  int  sine_lut[TBL_DEPTH];

  initial begin
    longint unsigned t, quad, rem, m, x, x2, term, v;
    longint sum;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      t = 4 * k;
      quad = t / TBL_DEPTH;
      rem = t % TBL_DEPTH;
      m = quad[0] ? TBL_DEPTH - rem : rem;
      x = m * HALF_PI / TBL_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      sine_lut[k] = (quad >= 2) ? -int'(v) : int'(v);
    end
  end

  function automatic longint unsigned beat_index(input longint unsigned p,
                                                output longint unsigned frac);
    longint unsigned q, r;
    q = p / r_spb;
    r = p % r_spb;
    frac = (r * 256) % r_spb;
    return q * 256 + (r * 256) / r_spb;
  endfunction

  function automatic logic signed [15:0] click_value();
    longint unsigned stp, ph, idx, mag, den, q;
    int s;
    stp = acc_flag ? r_hstep : r_lstep;
    ph = (longint'(click_pos) * stp) & 64'hFF_FFFF;
    idx = (ph * TBL_DEPTH) >> 24;
    s = sine_lut[idx];
    mag = longint'(s < 0 ? -s : s) * (r_len - click_pos) * r_gain;
    den = longint'(r_len) << 14;
    q = (2 * mag + den) / (2 * den);
    if (s < 0) begin
      if (q > 32768) q = 32768;
      return -16'(q);
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  task automatic predict_word(input logic k, input logic signed [47:0] sp);
    click_word_t w;
    longint unsigned b, frac, off;
    w = '0;
    if (k) begin
      pos = longint'(sp) & POS_MASK;
      click_pos = -1;
      if (r_spb != 0 && !pos[47]) begin
        b = beat_index(pos, frac);
        off = (frac + 255) / 256;
        if (off <= r_tol) begin
          if (b == 0) last_ok = 0;
          else begin
            last_beat = b - 1;
            last_ok = 1;
          end
        end else begin
          last_beat = b;
          last_ok = 1;
        end
      end else last_ok = 0;
    end else if (r_active && r_spb != 0) begin
      if (!pos[47]) begin
        b = beat_index(pos, frac);
        if (!last_ok || b != last_beat) begin
          last_beat = b;
          last_ok = 1;
          acc_flag = (b % ((r_bpb != 0) ? r_bpb : 5'd1)) == 0;
          click_pos = 0;
          w.bs = 1;
        end
        if (click_pos >= 0 && click_pos < r_len) begin
          w.smp = click_value();
          w.acc = acc_flag;
          click_pos++;
        end
      end
      pos = (pos + 1) & POS_MASK;
    end
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    click_word_t e;
    if (rst) begin
      r_active = 0; r_gain = GAIN_RST; r_bpb = BPB_RST; r_spb = SPB_RST;
      r_len = CLICK_LEN_RST; r_tol = SEEK_TOL_RST;
      r_hstep = HIGH_STEP_RST; r_lstep = LOW_STEP_RST;
      pos = 0; last_beat = 0; last_ok = 0; click_pos = -1; acc_flag = 0;
      expected_words.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ACTIVE: begin
            r_active = pwdata[0];
            click_pos = -1;
          end
          REG_GAIN:      r_gain = pwdata[15:0];
          REG_BPB:       r_bpb = pwdata[4:0];
          REG_SPB:       r_spb = pwdata;
          REG_CLICK_LEN: r_len = pwdata[15:0];
          REG_SEEK_TOL:  r_tol = pwdata[15:0];
          REG_HIGH_STEP: r_hstep = pwdata[22:0];
          REG_LOW_STEP:  r_lstep = pwdata[22:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) predict_word(kind, seek_position);
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word sample=%0d beat_start=%0b accent=%0b",
                   $time, sample, beat_start, accent);
          errors <= errors + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.smp !== sample || e.bs !== beat_start || e.acc !== accent) begin
            $display({"%0t: mismatch expected sample=%0d beat_start=%0b accent=%0b,",
                      " got %0d %0b %0b"},
                     $time, e.smp, e.bs, e.acc, sample, beat_start, accent);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= expected_words.size();
  end
endmodule

>>> tb/sv/testbench.sv
// Top of the metronome click generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import mcg_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic req_valid, req_ready, kind, rsp_valid, rsp_ready;
  logic signed [47:0] seek_position;
  logic signed [15:0] sample;
  logic beat_start, accent;
  int errors, pending, cycles;
  int send_idle, recv_idle;
  bit hold_rsp;

  metronome_click_generator DUT (.*);
  mcg_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rsp_ready = 0;
    hold_rsp = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ready <= 0;
        repeat (400) @(posedge clk);
        hold_rsp = 0;
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_word(input logic k, input logic signed [47:0] sp);
    if ($urandom_range(99) < send_idle) begin
      req_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    req_valid <= 1; kind <= k; seek_position <= sp;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_word(1'b0, 48'($urandom));
  endtask

  initial begin
    logic [31:0] spb;
    longint beat_len;
    logic signed [47:0] sp;
    cycles = 0;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    req_valid = 0; kind = 0; seek_position = 0;
    send_idle = 0; recv_idle = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: inactive, negative and wrapping positions, seek re-arm, saturation
    send_word(1'b0, 48'sd0);
    send_word(1'b1, 48'sd40);
    drain();
    reg_write(REG_SPB, 32'd20 * 32'd256);
    reg_write(REG_CLICK_LEN, 32'd6);
    reg_write(REG_BPB, 32'd3);
    reg_write(REG_GAIN, 32'hFFFF);
    reg_write(REG_SEEK_TOL, 32'd2);
    reg_write(REG_HIGH_STEP, 32'h7FFFFF);
    reg_write(REG_LOW_STEP, 32'd0);
    reg_write(REG_ACTIVE, 32'd1);
    send_word(1'b1, -48'sd3);
    tick_run(5);
    send_word(1'b1, 48'sh7FFF_FFFF_FFFE);
    tick_run(3);
    send_word(1'b1, 48'sd40);
    tick_run(2);
    send_word(1'b1, 48'sd45);
    tick_run(2);
    send_word(1'b1, 48'sh8000_0000_0000);
    send_word(1'b0, 48'sd0);
    drain();
    reg_write(REG_BPB, 32'd0);
    reg_write(REG_SPB, 32'd0);
    send_word(1'b0, 48'sd0);
    send_word(1'b1, 48'sd7);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 21 : (ph < 4) ? 53 : 0;
      recv_idle = (ph < 2) ? 53 : (ph < 4) ? 21 : 0;
      case (ph)
        1: spb = 32'd1;
        3: spb = 32'hFFFF_FFFF;
        default: spb = $urandom_range(40 * 256, 3 * 256);
      endcase
      reg_write(REG_SPB, spb);
      reg_write(REG_CLICK_LEN, 32'((ph == 2) ? 16'hFFFF : (ph == 5) ? 16'd0 :
                16'($urandom_range(30, 1))));
      reg_write(REG_GAIN,
                32'((ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF : 16'($urandom)));
      reg_write(REG_BPB, 32'(5'($urandom_range(31))));
      reg_write(REG_SEEK_TOL, 32'((ph == 4) ? 16'hFFFF : 16'($urandom_range(10))));
      reg_write(REG_HIGH_STEP, 32'((ph == 1) ? 23'h7FFFFF : 23'($urandom)));
      reg_write(REG_LOW_STEP, 32'((ph == 1) ? 23'd0 : 23'($urandom)));
      reg_write(REG_ACTIVE, (ph == 3) ? 32'd0 : 32'd1);
      if (ph == 3) begin
        tick_run(4);
        drain();
        reg_write(REG_ACTIVE, 32'd1);
      end
      if (ph == 4) hold_rsp = 1;
      beat_len = (spb >> 8) + 1;
      for (int i = 0; i < 190; i++) begin
        case ($urandom_range(19))
          0: begin
            sp = 48'(beat_len * $urandom_range(50)) + 48'($urandom_range(12)) - 48'sd2;
            send_word(1'b1, sp);
          end
          1: send_word(1'b1, 48'({$urandom, $urandom}));
          2: send_word(1'b1, -48'($urandom_range(6)));
          default: send_word(1'b0, 48'({$urandom, $urandom}));
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
